>>> rtl/bdar_pkg.sv
// Package for the button debounce and auto-repeat block.
// Holds the transfer payload types, the configuration struct and the code constants.
// No dependencies.
`default_nettype none

package bdar_pkg;

    localparam int unsigned TIME_W   = 32;
    localparam int unsigned PORT_W   = 16;
    localparam int unsigned CMD_W    = 2;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // Command codes; code 3 is unused and ignored.
    localparam logic [CMD_W-1:0] CMD_SAMPLE = 2'd0;
    localparam logic [CMD_W-1:0] CMD_POLL   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESET  = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] REG_CONTACT_MASK = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REP_THRESH   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_REP_INTERVAL = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REP_ENABLE   = 3'd4;

    // Register reset values.
    localparam logic [PORT_W-1:0] CONTACT_MASK_RST = 16'd3;
    localparam logic [15:0]       DEBOUNCE_RST     = 16'd20;
    localparam logic [TIME_W-1:0] ALL_ONES_32      = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [PORT_W-1:0] port_state;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic              press_event;
        logic              repeat_event;
        logic [TIME_W-1:0] held_ms;
    } t_out_item;

    typedef struct packed {
        logic [PORT_W-1:0] contact_mask;
        logic [15:0]       debounce_ms;
        logic [TIME_W-1:0] repeat_threshold_ms;
        logic [TIME_W-1:0] repeat_interval_ms;
        logic              repeat_enable;
    } t_cfg;

endpackage

`default_nettype wire

>>> rtl/bdar_cfg_regs.sv
// Configuration register file for the button debounce and auto-repeat block.
// Depends on bdar_pkg for the register indexes, reset values and t_cfg.
`default_nettype none

module bdar_cfg_regs
    import bdar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata,
    output t_cfg                       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.contact_mask        <= CONTACT_MASK_RST;
            r_cfg.debounce_ms         <= DEBOUNCE_RST;
            r_cfg.repeat_threshold_ms <= ALL_ONES_32;
            r_cfg.repeat_interval_ms  <= ALL_ONES_32;
            r_cfg.repeat_enable       <= 1'b0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_CONTACT_MASK: r_cfg.contact_mask        <= i_cfg_wdata[PORT_W-1:0];
                REG_DEBOUNCE:     r_cfg.debounce_ms         <= i_cfg_wdata[15:0];
                REG_REP_THRESH:   r_cfg.repeat_threshold_ms <= i_cfg_wdata[TIME_W-1:0];
                REG_REP_INTERVAL: r_cfg.repeat_interval_ms  <= i_cfg_wdata[TIME_W-1:0];
                REG_REP_ENABLE:   r_cfg.repeat_enable       <= i_cfg_wdata[0];
                default: begin
                    // Writes beyond the register list are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

>>> rtl/bdar_engine.sv
// Debounce and auto-repeat state with the per-item decision logic.
// Depends on bdar_pkg for the payload types, command codes and t_cfg.
`default_nettype none

module bdar_engine
    import bdar_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_fire,
    input  wire t_in_item i_item,
    input  wire t_cfg     i_cfg,
    output t_out_item  o_result
);

    logic              r_seeded;
    logic              r_raw_level;
    logic              r_press_held;
    logic [TIME_W-1:0] r_last_change;
    logic [TIME_W-1:0] r_press_start;
    logic [TIME_W-1:0] r_last_repeat;

    logic              n_seeded;
    logic              n_raw_level;
    logic              n_press_held;
    logic [TIME_W-1:0] n_last_change;
    logic [TIME_W-1:0] n_press_start;
    logic [TIME_W-1:0] n_last_repeat;

    logic              level;
    logic [TIME_W-1:0] since_change;
    logic [TIME_W-1:0] held;
    logic [TIME_W-1:0] since_repeat;
    logic [TIME_W-1:0] interval;
    t_out_item         result;

    assign level        = (i_item.port_state & i_cfg.contact_mask) == i_cfg.contact_mask;
    assign since_change = i_item.now_ms - r_last_change;
    assign held         = i_item.now_ms - r_press_start;
    assign since_repeat = i_item.now_ms - r_last_repeat;
    assign interval     = (i_cfg.repeat_interval_ms == '0) ? TIME_W'(1)
                                                           : i_cfg.repeat_interval_ms;

    always_comb begin
        n_seeded      = r_seeded;
        n_raw_level   = r_raw_level;
        n_press_held  = r_press_held;
        n_last_change = r_last_change;
        n_press_start = r_press_start;
        n_last_repeat = r_last_repeat;
        result        = '0;

        unique case (i_item.command)
            CMD_SAMPLE: begin
                if (!r_seeded) begin
                    n_seeded    = 1'b1;
                    n_raw_level = level;
                end else if (level != r_raw_level) begin
                    if (level) begin
                        if (since_change >= {16'd0, i_cfg.debounce_ms}) begin
                            n_press_start      = i_item.now_ms;
                            n_last_repeat      = i_item.now_ms;
                            n_press_held       = 1'b1;
                            result.press_event = 1'b1;
                        end
                    end else begin
                        n_press_held = 1'b0;
                    end
                    n_raw_level   = level;
                    n_last_change = i_item.now_ms;
                end
            end
            CMD_POLL: begin
                if (r_press_held && i_cfg.repeat_enable &&
                    held >= i_cfg.repeat_threshold_ms && since_repeat >= interval) begin
                    n_last_repeat       = i_item.now_ms;
                    result.repeat_event = 1'b1;
                    result.held_ms      = held;
                end
            end
            CMD_RESET: begin
                n_seeded      = 1'b0;
                n_raw_level   = 1'b0;
                n_press_held  = 1'b0;
                n_last_change = i_item.now_ms;
                n_press_start = i_item.now_ms;
                n_last_repeat = i_item.now_ms;
            end
            default: begin
                // The unused code changes nothing.
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seeded      <= 1'b0;
            r_raw_level   <= 1'b0;
            r_press_held  <= 1'b0;
            r_last_change <= '0;
            r_press_start <= '0;
            r_last_repeat <= '0;
        end else if (i_fire) begin
            r_seeded      <= n_seeded;
            r_raw_level   <= n_raw_level;
            r_press_held  <= n_press_held;
            r_last_change <= n_last_change;
            r_press_start <= n_press_start;
            r_last_repeat <= n_last_repeat;
        end
    end

    assign o_result = result;

    a_events_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(result.press_event && result.repeat_event))
        else $error("press and repeat events in the same result");

    a_held_only_on_repeat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !result.repeat_event |-> result.held_ms == '0)
        else $error("hold time reported without a repeat event");

    a_press_sets_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_fire && result.press_event |=> r_press_held && r_raw_level)
        else $error("accepted press did not latch the held flag");

    a_held_needs_seed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_press_held |-> r_seeded && r_raw_level)
        else $error("held flag set while unseeded or released");

endmodule

`default_nettype wire

>>> rtl/button_debounce_autorepeat_top.sv
// Top level of the button debounce and auto-repeat block.
// Depends on bdar_pkg, bdar_cfg_regs and bdar_engine.
`default_nettype none

// The block watches a two-contact push button through samples of a 16-bit port
// and turns them into debounced press events and auto-repeat events. Each input
// transfer carries a command (port sample, poll tick or reset), the port levels
// and the current millisecond time; each one yields exactly one result transfer.
// An item is captured in an input register; as it leaves that register, the
// decision logic updates the button state and loads the result register, and
// one item is taken in every cycle while the result side keeps
// up. The rate is set by the single state-update stage: it needs only a few
// 32-bit subtractions and compares. When the result side stalls, the input
// register still holds one item and input ready drops only once both registers
// are full. Configuration is written through a plain write port and must only
// change while no item is in flight.

module button_debounce_autorepeat_top
    import bdar_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_ready,
    input  wire t_in_item              i_in_item,
    output logic                       o_out_valid,
    input  wire logic                  i_out_ready,
    output t_out_item                  o_out_item,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_wdata
);

    t_cfg      cfg;
    t_out_item result;

    logic      r_s1_valid;
    t_in_item  r_s1_item;
    logic      r_out_valid;
    t_out_item r_out_item;

    logic      out_free;
    logic      s1_advance;
    logic      in_accept;

    // The result register can load when it is empty or being drained now.
    assign out_free   = !r_out_valid || i_out_ready;
    assign s1_advance = r_s1_valid && out_free;
    assign o_in_ready = !r_s1_valid || out_free;
    assign in_accept  = i_in_valid && o_in_ready;

    bdar_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    // The state only moves when the captured item passes into the result register.
    bdar_engine u_engine (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_fire   (s1_advance),
        .i_item   (r_s1_item),
        .i_cfg    (cfg),
        .o_result (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_accept) begin
                r_s1_valid <= 1'b1;
            end else if (s1_advance) begin
                r_s1_valid <= 1'b0;
            end
            if (out_free) begin
                r_out_valid <= r_s1_valid;
            end
        end
    end

    // The input register is cleared so the decision logic sees a known item
    // before the first transfer arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_item <= '0;
        end else if (in_accept) begin
            r_s1_item <= i_in_item;
        end
        if (s1_advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    a_stage_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && !out_free |=> r_s1_valid)
        else $error("captured item lost while the result side stalled");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input ready while both registers are full");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s1_advance |=> r_out_valid)
        else $error("advanced item did not reach the result register");

endmodule

`default_nettype wire
